// ===== design/lbpc_pkg.sv =====
package lbpc_pkg;

	localparam int NUM_LEDS_DEF  = 4;
	localparam int TICK_BITS_DEF = 16;
	localparam int PIN_BITS      = 4;
	localparam int IDX_BITS      = 2;
	localparam int FIELD_BITS    = 16;
	localparam int COUNT_BITS    = 8;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_SET     = 3'd1,
		OP_BLINK   = 3'd2,
		OP_COUNTED = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_STEADY  = 2'd0,
		MODE_BLINK   = 2'd1,
		MODE_COUNTED = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} seq_state_t;

	typedef struct packed {
		logic [2:0]            op;
		logic [IDX_BITS-1:0]   led_index;
		logic                  level;
		logic [FIELD_BITS-1:0] blink_delay;
		logic [FIELD_BITS-1:0] burst_pause;
		logic [COUNT_BITS-1:0] blink_count;
	} cmd_t;

	typedef struct packed {
		logic accept;
		logic is_tick;
		logic last;
		logic out_free;
	} seq_status_t;

	typedef struct packed {
		logic ready;
		logic sweep;
		logic load;
	} seq_ctrl_t;

endpackage

// ===== design/lbpc_if.sv =====
interface lbpc_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [1:0]  led_index;
	logic        level;
	logic [15:0] blink_delay;
	logic [15:0] burst_pause;
	logic [7:0]  blink_count;

	modport source (output valid, op, led_index, level, blink_delay, burst_pause, blink_count,
		input ready);
	modport sink (input valid, op, led_index, level, blink_delay, burst_pause, blink_count,
		output ready);
endinterface

interface lbpc_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] pin_levels;
	logic       read_level;

	modport source (output valid, pin_levels, read_level, input ready);
	modport sink (input valid, pin_levels, read_level, output ready);
endinterface

// ===== design/led_blink_pattern_controller_top.sv =====
// A command is registered, applied in the sweep step and its result loaded at finish;
// a tick sweeps all LEDs first. A new command is taken only once that result is loaded.
// A tick walks the LED timers one per cycle through a single shared update unit.
// The result sits in an output register, so a new transfer is taken while it waits.
// Reset clears all LED state, the sequencer and the result valid; active_high resets to 1.
module led_blink_pattern_controller_top #(
	parameter int NUM_LEDS  = lbpc_pkg::NUM_LEDS_DEF,
	parameter int TICK_BITS = lbpc_pkg::TICK_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	lbpc_cmd_if.sink      cmd,
	lbpc_result_if.source result
);

	localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

	typedef struct packed {
		lbpc_pkg::mode_t                 mode;
		logic [TICK_BITS-1:0]            toggle;
		logic [TICK_BITS-1:0]            pause;
		logic [lbpc_pkg::COUNT_BITS-1:0] target;
		logic [lbpc_pkg::COUNT_BITS-1:0] done;
		logic [TICK_BITS-1:0]            ticks;
	} entry_t;

	logic                          active_high_q;
	lbpc_pkg::cmd_t                cmd_q;
	logic [NUM_LEDS-1:0]           lit_q;
	entry_t                        entry_q [NUM_LEDS];
	logic [LED_W-1:0]              cursor_q;
	logic                          res_valid_q;
	logic [lbpc_pkg::PIN_BITS-1:0] pins_q;
	logic                          rd_q;

	lbpc_pkg::seq_status_t status;
	lbpc_pkg::seq_ctrl_t   ctrl;
	lbpc_pkg::seq_state_t  state;

	logic                          is_tick;
	logic                          idx_ok;
	logic [LED_W-1:0]              addr;
	logic                          upd_lit;
	entry_t                        upd_ent;
	logic                          upd_we;
	logic                          wr_en;
	logic [lbpc_pkg::PIN_BITS-1:0] pins;
	logic                          rd;

	assign is_tick = lbpc_pkg::op_t'(cmd_q.op) == lbpc_pkg::OP_TICK;
	assign idx_ok  = 32'(cmd_q.led_index) < NUM_LEDS;
	assign addr    = is_tick ? cursor_q : LED_W'(cmd_q.led_index);
	assign wr_en   = ctrl.sweep && upd_we && (is_tick || idx_ok);

	assign status.accept   = cmd.valid && ctrl.ready;
	assign status.is_tick  = is_tick;
	assign status.last     = cursor_q == LED_W'(NUM_LEDS - 1);
	assign status.out_free = !res_valid_q || result.ready;

	assign cmd.ready = ctrl.ready;

	lbpc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.state  (state)
	);

	lbpc_update #(
		.TICK_BITS (TICK_BITS)
	) u_update (
		.cmd     (cmd_q),
		.lit_in  (lit_q[addr]),
		.ent_in  (entry_q[addr]),
		.lit_out (upd_lit),
		.ent_out (upd_ent),
		.we      (upd_we)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
		end else if (cfg_we) begin
			active_high_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (status.accept) begin
			cmd_q.op          <= cmd.op;
			cmd_q.led_index   <= cmd.led_index;
			cmd_q.level       <= cmd.level;
			cmd_q.blink_delay <= cmd.blink_delay;
			cmd_q.burst_pause <= cmd.burst_pause;
			cmd_q.blink_count <= cmd.blink_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (status.accept) begin
			cursor_q <= '0;
		end else if (ctrl.sweep && is_tick && !status.last) begin
			cursor_q <= cursor_q + LED_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q <= '0;
			for (int i = 0; i < NUM_LEDS; i++) begin
				entry_q[i] <= '0;
			end
		end else if (wr_en) begin
			lit_q[addr]   <= upd_lit;
			entry_q[addr] <= upd_ent;
		end
	end

	for (genvar g = 0; g < lbpc_pkg::PIN_BITS; g++) begin : g_pin
		if (g < NUM_LEDS) begin : g_led
			assign pins[g] = lit_q[g] ^ ~active_high_q;
		end else begin : g_none
			assign pins[g] = 1'b0;
		end
	end

	always_comb begin
		rd = 1'b0;
		if (lbpc_pkg::op_t'(cmd_q.op) == lbpc_pkg::OP_READ && idx_ok) begin
			rd = lit_q[LED_W'(cmd_q.led_index)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pins_q <= pins;
			rd_q   <= rd;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.pin_levels = pins_q;
	assign result.read_level = rd_q;

`ifndef ASSERT_OFF
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state != lbpc_pkg::ST_IDLE |-> !cmd.ready)
		else $error("command taken while an item is in progress");

	a_steady_no_timer: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && upd_ent.mode == lbpc_pkg::MODE_STEADY |-> upd_ent.ticks == '0)
		else $error("steady LED left with a running timer");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= LED_W'(NUM_LEDS - 1))
		else $error("sweep cursor beyond the LED bank");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state == lbpc_pkg::ST_FINISH))
		else $error("result raised outside the finish step");
`endif

endmodule

// ===== design/lbpc_update.sv =====
module lbpc_update #(
	parameter int TICK_BITS = lbpc_pkg::TICK_BITS_DEF
) (
	input  lbpc_pkg::cmd_t cmd,
	input  logic           lit_in,
	input  logic [$bits(lbpc_pkg::mode_t)+2*lbpc_pkg::COUNT_BITS+3*TICK_BITS-1:0] ent_in,
	output logic           lit_out,
	output logic [$bits(lbpc_pkg::mode_t)+2*lbpc_pkg::COUNT_BITS+3*TICK_BITS-1:0] ent_out,
	output logic           we
);

	typedef struct packed {
		lbpc_pkg::mode_t                 mode;
		logic [TICK_BITS-1:0]            toggle;
		logic [TICK_BITS-1:0]            pause;
		logic [lbpc_pkg::COUNT_BITS-1:0] target;
		logic [lbpc_pkg::COUNT_BITS-1:0] done;
		logic [TICK_BITS-1:0]            ticks;
	} entry_t;

	entry_t                          cur;
	entry_t                          nxt;
	logic [TICK_BITS-1:0]            delay_t;
	logic [TICK_BITS-1:0]            pause_t;
	logic [TICK_BITS-1:0]            ld_delay;
	logic [TICK_BITS-1:0]            ld_toggle;
	logic [TICK_BITS-1:0]            ld_pause;
	logic [TICK_BITS-1:0]            t_dec;
	logic [lbpc_pkg::COUNT_BITS-1:0] done_inc;

	assign cur       = entry_t'(ent_in);
	assign ent_out   = nxt;
	assign delay_t   = TICK_BITS'(cmd.blink_delay);
	assign pause_t   = TICK_BITS'(cmd.burst_pause);
	assign ld_delay  = (delay_t == '0) ? TICK_BITS'(1) : delay_t;
	assign ld_toggle = (cur.toggle == '0) ? TICK_BITS'(1) : cur.toggle;
	assign ld_pause  = (cur.pause == '0) ? TICK_BITS'(1) : cur.pause;
	assign t_dec     = cur.ticks - TICK_BITS'(1);
	assign done_inc  = cur.done + lbpc_pkg::COUNT_BITS'(1);

	always_comb begin
		logic [lbpc_pkg::COUNT_BITS-1:0] done_n;
		nxt     = cur;
		lit_out = lit_in;
		we      = 1'b0;
		done_n  = cur.done;
		case (lbpc_pkg::op_t'(cmd.op))
			lbpc_pkg::OP_TICK: begin
				we = 1'b1;
				if (cur.ticks != '0) begin
					nxt.ticks = t_dec;
					if (t_dec == '0) begin
						case (cur.mode)
							lbpc_pkg::MODE_BLINK: begin
								lit_out   = ~lit_in;
								nxt.ticks = ld_toggle;
							end
							lbpc_pkg::MODE_COUNTED: begin
								lit_out  = ~lit_in;
								done_n   = lit_in ? done_inc : cur.done;
								nxt.done = done_n;
								if (done_n < cur.target) begin
									nxt.ticks = ld_toggle;
								end else if (cur.pause != '0) begin
									nxt.ticks = ld_pause;
									nxt.done  = '0;
								end else begin
									nxt.mode  = lbpc_pkg::MODE_STEADY;
									nxt.ticks = '0;
								end
							end
							default: begin
								nxt.ticks = '0;
							end
						endcase
					end
				end
			end
			lbpc_pkg::OP_SET: begin
				we        = 1'b1;
				nxt.ticks = '0;
				nxt.mode  = lbpc_pkg::MODE_STEADY;
				lit_out   = cmd.level;
			end
			lbpc_pkg::OP_BLINK: begin
				we         = 1'b1;
				nxt.mode   = lbpc_pkg::MODE_BLINK;
				nxt.toggle = delay_t;
				nxt.ticks  = ld_delay;
			end
			lbpc_pkg::OP_COUNTED: begin
				we         = 1'b1;
				nxt.mode   = lbpc_pkg::MODE_COUNTED;
				nxt.target = cmd.blink_count;
				nxt.toggle = delay_t;
				nxt.pause  = pause_t;
				nxt.done   = '0;
				nxt.ticks  = ld_delay;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/lbpc_seq.sv =====
module lbpc_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lbpc_pkg::seq_status_t status,
	output lbpc_pkg::seq_ctrl_t   ctrl,
	output lbpc_pkg::seq_state_t  state
);

	lbpc_pkg::seq_state_t state_q;
	lbpc_pkg::seq_state_t state_n;

	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			lbpc_pkg::ST_IDLE: begin
				if (status.accept) begin
					state_n = lbpc_pkg::ST_SWEEP;
				end
			end
			lbpc_pkg::ST_SWEEP: begin
				if (!status.is_tick || status.last) begin
					state_n = lbpc_pkg::ST_FINISH;
				end
			end
			lbpc_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_n = lbpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = lbpc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			lbpc_pkg::ST_IDLE: begin
				ctrl.ready = 1'b1;
			end
			lbpc_pkg::ST_SWEEP: begin
				ctrl.sweep = 1'b1;
			end
			lbpc_pkg::ST_FINISH: begin
				ctrl.load = status.out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule
